[hw/rtl/rae_pkg.sv]
// Shared types and constants of the register-execute block: operation codes,
// item and write-port structs, flag positions and the msb carry/overflow tables.
// No dependencies.
package rae_pkg;

  localparam int NUM_REGS  = 8;
  localparam int WORD_BITS = 16;
  localparam int REG_W     = 3;
  localparam int OP_W      = 5;
  localparam int BYTE_W    = 8;
  localparam int FLAG_W    = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // status word bit positions
  localparam int FLAG_C   = 0;
  localparam int FLAG_Z   = 1;
  localparam int FLAG_N   = 2;
  localparam int FLAG_SLP = 3;
  localparam int FLAG_V   = 4;

  // indexed by {source msb (inverted on subtract), destination msb, result msb}
  localparam logic [7:0] CARRY_TAB = 8'b1101_0100;
  localparam logic [7:0] OVF_TAB   = 8'b0100_0010;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADDC  = 5'd1,
    OP_SUB   = 5'd2,
    OP_SUBC  = 5'd3,
    OP_DADD  = 5'd4,
    OP_CMP   = 5'd5,
    OP_XOR   = 5'd6,
    OP_AND   = 5'd7,
    OP_OR    = 5'd8,
    OP_BIT   = 5'd9,
    OP_BIC   = 5'd10,
    OP_BIS   = 5'd11,
    OP_MOV   = 5'd12,
    OP_SWAP  = 5'd13,
    OP_SRA   = 5'd14,
    OP_RRC   = 5'd15,
    OP_SWPB  = 5'd16,
    OP_SXT   = 5'd17,
    OP_SETCC = 5'd18,
    OP_CLRCC = 5'd19,
    OP_MOVL  = 5'd20,
    OP_MOVLZ = 5'd21,
    OP_MOVLS = 5'd22,
    OP_MOVH  = 5'd23
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [REG_W-1:0]     dest_reg;
    logic [REG_W-1:0]     src_reg;
    logic                 src_is_constant;
    logic [WORD_BITS-1:0] constant_value;
    logic                 byte_mode;
    logic [BYTE_W-1:0]    byte_value;
    logic [FLAG_W-1:0]    cc_mask;
  } item_t;

  // two register-file write ports; port b wins when both hit one register
  typedef struct packed {
    logic                 we_a;
    logic [REG_W-1:0]     addr_a;
    logic [WORD_BITS-1:0] data_a;
    logic                 we_b;
    logic [REG_W-1:0]     addr_b;
    logic [WORD_BITS-1:0] data_b;
  } rf_wr_t;

endpackage

[hw/rtl/risc_alu_register_execute.sv]
// Top level of the 16-bit register-execute stage: input register, execute
// logic, register file, status word and result register.
// Depends on rae_pkg, rae_regfile and rae_exec.
// A taken input beat is held in the instruction register, then executed into the result register, which offers it.
// Throughput: one instruction per cycle; a stalled result takes one more beat, then holds input.
// Reset (rst_n low, synchronous) zeroes the general registers, the status word and both valids.
module risc_alu_register_execute (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [4:0] operation, [7:5] dest_reg, [10:8] src_reg, [11] src_is_constant,
  // [27:12] constant_value, [28] byte_mode, [36:29] byte_value, [41:37] cc_mask,
  // [47:42] zero
  input  logic [rae_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] result_value, [20:16] status_flags, [23:21] zero
  output logic [rae_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  rae_pkg::item_t                in_item;
  logic                          in_fire;
  logic                          exe_fire;

  logic                          s1_valid_r;
  rae_pkg::item_t                s1_item_r;
  logic [rae_pkg::WORD_BITS-1:0] dst_full;
  logic [rae_pkg::WORD_BITS-1:0] src_full;

  logic [rae_pkg::FLAG_W-1:0]    status_r;
  logic [rae_pkg::FLAG_W-1:0]    status_nxt;
  rae_pkg::rf_wr_t               rf_wr;
  logic [rae_pkg::WORD_BITS-1:0] exe_result;

  logic                          out_valid_r;
  logic [rae_pkg::WORD_BITS-1:0] out_result_r;
  logic [rae_pkg::FLAG_W-1:0]    out_status_r;

  // unpack the input beat
  assign in_item.operation       = in_tdata[4:0];
  assign in_item.dest_reg        = in_tdata[7:5];
  assign in_item.src_reg         = in_tdata[10:8];
  assign in_item.src_is_constant = in_tdata[11];
  assign in_item.constant_value  = in_tdata[27:12];
  assign in_item.byte_mode       = in_tdata[28];
  assign in_item.byte_value      = in_tdata[36:29];
  assign in_item.cc_mask         = in_tdata[41:37];

  // execute when the instruction register is full and the result slot frees up
  assign exe_fire  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || exe_fire;
  assign in_fire   = in_tvalid && in_tready;

  // operand reads happen as the beat is taken; writes of the instruction
  // retiring at that edge are forwarded, so back-to-back dependencies hold
  rae_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_item.dest_reg),
    .rd_addr_b (in_item.src_reg),
    .wr        (exe_fire ? rf_wr : '0),
    .rd_data_a (dst_full),
    .rd_data_b (src_full)
  );

  rae_exec u_exec (
    .item       (s1_item_r),
    .dst_full   (dst_full),
    .src_full   (src_full),
    .status     (status_r),
    .wr         (rf_wr),
    .result     (exe_result),
    .status_nxt (status_nxt)
  );

  // instruction register: load on accept, drop once executed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (exe_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
  end

  // status word advances only as an instruction retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
    end else if (exe_fire) begin
      status_r <= status_nxt;
    end
  end

  // result register: hold while stalled, advance on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exe_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_fire) begin
      out_result_r <= exe_result;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_status_r, out_result_r};

  // the status shown on a waiting result beat is the live status word
  a_out_status_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == status_r))
    else $error("result beat status differs from status word");

  // status word changes only when an instruction retires
  a_status_hold: assert property (@(posedge clk)
    rst_n && $past(rst_n) && !$past(exe_fire) |-> $stable(status_r))
    else $error("status word changed without a retiring instruction");

  // the sleep flag is touched only by setcc and clrcc
  a_slp_only_cc: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(exe_fire) &&
    $past(s1_item_r.operation) != rae_pkg::OP_SETCC &&
    $past(s1_item_r.operation) != rae_pkg::OP_CLRCC
    |-> status_r[rae_pkg::FLAG_SLP] == $past(status_r[rae_pkg::FLAG_SLP]))
    else $error("slp flag changed by an operation other than setcc/clrcc");

  // an executed instruction always leaves a result beat behind
  a_exe_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    exe_fire |=> out_valid_r)
    else $error("retired instruction produced no result beat");

endmodule

[hw/rtl/rae_regfile.sv]
// General register file: flip-flop array with two write ports and two registered
// read ports that forward same-cycle writes. Depends on rae_pkg.
module rae_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [rae_pkg::REG_W-1:0]     rd_addr_a,
  input  logic [rae_pkg::REG_W-1:0]     rd_addr_b,
  input  rae_pkg::rf_wr_t               wr,
  output logic [rae_pkg::WORD_BITS-1:0] rd_data_a,
  output logic [rae_pkg::WORD_BITS-1:0] rd_data_b
);

  logic [rae_pkg::WORD_BITS-1:0] regs_r [rae_pkg::NUM_REGS];
  logic [rae_pkg::WORD_BITS-1:0] rd_data_a_r;
  logic [rae_pkg::WORD_BITS-1:0] rd_data_b_r;

  // register beyond the file reads as zero; pending writes are forwarded
  function automatic logic [rae_pkg::WORD_BITS-1:0] read_fwd(
    input logic [rae_pkg::REG_W-1:0] addr
  );
    logic [rae_pkg::WORD_BITS-1:0] v;
    v = '0;
    for (int i = 0; i < rae_pkg::NUM_REGS; i++) begin
      if (i == int'(addr)) v = regs_r[i];
    end
    if (wr.we_a && wr.addr_a == addr) v = wr.data_a;
    if (wr.we_b && wr.addr_b == addr) v = wr.data_b;
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rae_pkg::NUM_REGS; i++) regs_r[i] <= '0;
    end else begin
      for (int i = 0; i < rae_pkg::NUM_REGS; i++) begin
        if (wr.we_a && int'(wr.addr_a) == i) regs_r[i] <= wr.data_a;
        if (wr.we_b && int'(wr.addr_b) == i) regs_r[i] <= wr.data_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= read_fwd(rd_addr_a);
      rd_data_b_r <= read_fwd(rd_addr_b);
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

[hw/rtl/rae_exec.sv]
// Combinational execute logic: one decoded instruction against its operand
// registers and the status word, giving register writes, result and new flags.
// Depends on rae_pkg.
module rae_exec (
  input  rae_pkg::item_t                item,
  input  logic [rae_pkg::WORD_BITS-1:0] dst_full,
  input  logic [rae_pkg::WORD_BITS-1:0] src_full,
  input  logic [rae_pkg::FLAG_W-1:0]    status,
  output rae_pkg::rf_wr_t               wr,
  output logic [rae_pkg::WORD_BITS-1:0] result,
  output logic [rae_pkg::FLAG_W-1:0]    status_nxt
);

  localparam int W = rae_pkg::WORD_BITS;

  rae_pkg::op_t op;
  logic         bm;
  logic         d_ok;
  logic         s_ok;
  logic [W-1:0] mask;
  logic [W-1:0] dv;
  logic [W-1:0] sv;
  logic [W-1:0] srv;

  logic         sub;
  logic         cin;
  logic [W-1:0] so;
  logic [W:0]   sum;
  logic [W-1:0] add_r;
  logic         sm;
  logic         dm;
  logic         rm;

  logic [W-1:0] dec_r;
  logic         dec_c;
  logic         cy;
  logic [4:0]   nib;

  logic [3:0]   bitn;
  logic [W-1:0] bit_t;

  logic         wd;
  logic [W-1:0] new_d;
  logic [W-1:0] r;

  function automatic logic msb_of(input logic [W-1:0] x, input logic byte_m);
    return byte_m ? x[7] : x[W-1];
  endfunction

  function automatic logic [W-1:0] merge(input logic [W-1:0] old_v,
                                         input logic [W-1:0] v,
                                         input logic [W-1:0] m);
    return (old_v & ~m) | (v & m);
  endfunction

  assign op   = rae_pkg::op_t'(item.operation);
  assign bm   = item.byte_mode;
  assign d_ok = int'(item.dest_reg) < rae_pkg::NUM_REGS;
  assign s_ok = int'(item.src_reg) < rae_pkg::NUM_REGS;
  assign mask = bm ? W'(16'h00FF) : W'(16'hFFFF);
  assign dv   = dst_full & mask;
  assign srv  = src_full & mask;
  assign sv   = (item.src_is_constant ? item.constant_value : src_full) & mask;

  // binary add / subtract
  assign sub   = (op == rae_pkg::OP_SUB) || (op == rae_pkg::OP_SUBC);
  assign cin   = (op == rae_pkg::OP_ADD) ? 1'b0 :
                 (op == rae_pkg::OP_SUB) ? 1'b1 : status[rae_pkg::FLAG_C];
  assign so    = sub ? (~sv & mask) : sv;
  assign sum   = {1'b0, dv} + {1'b0, so} + (W+1)'(cin);
  assign add_r = sum[W-1:0] & mask;
  assign sm    = msb_of(sv, bm) ^ sub;
  assign dm    = msb_of(dv, bm);
  assign rm    = msb_of(add_r, bm);

  // decimal add, one nibble per step; byte mode takes carry after nibble one
  always_comb begin
    dec_r = '0;
    dec_c = 1'b0;
    cy    = 1'b0;
    nib   = '0;
    for (int k = 0; k < W / 4; k++) begin
      nib = {1'b0, dv[4*k +: 4]} + {1'b0, sv[4*k +: 4]} + 5'(cy);
      cy  = nib > 5'd9;
      if (cy) nib = nib - 5'd10;
      dec_r[4*k +: 4] = nib[3:0];
      if (k == 1 && bm) dec_c = cy;
    end
    if (!bm) dec_c = cy;
  end

  // bit number modulo the operating width
  assign bitn  = bm ? {1'b0, sv[2:0]} : sv[3:0];
  assign bit_t = W'(1) << bitn;

  always_comb begin
    wd         = 1'b0;
    new_d      = dst_full;
    r          = '0;
    result     = '0;
    status_nxt = status;
    wr         = '0;
    case (op)
      rae_pkg::OP_ADD, rae_pkg::OP_ADDC, rae_pkg::OP_SUB, rae_pkg::OP_SUBC: begin
        wd = 1'b1;
        new_d = merge(dst_full, add_r, mask);
        status_nxt[rae_pkg::FLAG_N] = rm;
        status_nxt[rae_pkg::FLAG_Z] = (add_r == '0);
        status_nxt[rae_pkg::FLAG_V] = rae_pkg::OVF_TAB[{sm, dm, rm}];
        status_nxt[rae_pkg::FLAG_C] = rae_pkg::CARRY_TAB[{sm, dm, rm}];
      end
      rae_pkg::OP_DADD: begin
        r  = dec_r & mask;
        wd = 1'b1;
        new_d = merge(dst_full, r, mask);
        status_nxt[rae_pkg::FLAG_V] = 1'b0;
        status_nxt[rae_pkg::FLAG_N] = 1'b0;
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
        status_nxt[rae_pkg::FLAG_C] = dec_c;
      end
      rae_pkg::OP_CMP: begin
        status_nxt[rae_pkg::FLAG_N] = dv < sv;
        status_nxt[rae_pkg::FLAG_Z] = dv == sv;
        status_nxt[rae_pkg::FLAG_C] = dv >= sv;
        result = (dv - sv) & mask;
      end
      rae_pkg::OP_XOR, rae_pkg::OP_AND, rae_pkg::OP_OR: begin
        r = (op == rae_pkg::OP_XOR) ? (dv ^ sv) :
            (op == rae_pkg::OP_AND) ? (dv & sv) : (dv | sv);
        wd = 1'b1;
        new_d = merge(dst_full, r, mask);
        status_nxt[rae_pkg::FLAG_N] = msb_of(r, bm);
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
        if (op == rae_pkg::OP_XOR) status_nxt[rae_pkg::FLAG_V] = 1'b0;
      end
      rae_pkg::OP_BIT: begin
        r = dv & bit_t;
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
        result = r;
      end
      rae_pkg::OP_BIC, rae_pkg::OP_BIS: begin
        r = (op == rae_pkg::OP_BIC) ? (dv & ~bit_t & mask) : (dv | bit_t);
        wd = 1'b1;
        new_d = merge(dst_full, r, mask);
        status_nxt[rae_pkg::FLAG_N] = msb_of(r, bm);
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
      end
      rae_pkg::OP_MOV: begin
        wd = 1'b1;
        new_d = merge(dst_full, srv, mask);
      end
      rae_pkg::OP_SWAP: begin
        // both registers hold the same value when the numbers match
        wd = 1'b1;
        new_d = src_full;
        wr.we_b   = s_ok;
        wr.addr_b = item.src_reg;
        wr.data_b = dst_full;
      end
      rae_pkg::OP_SRA, rae_pkg::OP_RRC: begin
        r = dv >> 1;
        if (op == rae_pkg::OP_SRA) begin
          r = r | (dv & (bm ? W'(16'h0080) : W'(16'h8000)));
        end else if (status[rae_pkg::FLAG_C]) begin
          r = r | (bm ? W'(16'h0080) : W'(16'h8000));
        end
        wd = 1'b1;
        new_d = merge(dst_full, r, mask);
        status_nxt[rae_pkg::FLAG_N] = msb_of(r, bm);
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
        status_nxt[rae_pkg::FLAG_V] = 1'b0;
        status_nxt[rae_pkg::FLAG_C] = dv[0];
      end
      rae_pkg::OP_SWPB: begin
        r  = {dst_full[7:0], dst_full[W-1:8]};
        wd = 1'b1;
        new_d = r;
        status_nxt[rae_pkg::FLAG_N] = r[W-1];
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
      end
      rae_pkg::OP_SXT: begin
        r  = {{(W-8){dst_full[7]}}, dst_full[7:0]};
        wd = 1'b1;
        new_d = r;
        status_nxt[rae_pkg::FLAG_N] = r[W-1];
        status_nxt[rae_pkg::FLAG_Z] = (r == '0);
      end
      rae_pkg::OP_SETCC: status_nxt = status | item.cc_mask;
      rae_pkg::OP_CLRCC: status_nxt = status & ~item.cc_mask;
      rae_pkg::OP_MOVL: begin
        wd = 1'b1;
        new_d = {dst_full[W-1:8], item.byte_value};
      end
      rae_pkg::OP_MOVLZ: begin
        wd = 1'b1;
        new_d = {{(W-8){1'b0}}, item.byte_value};
      end
      rae_pkg::OP_MOVLS: begin
        wd = 1'b1;
        new_d = {{(W-8){1'b1}}, item.byte_value};
      end
      rae_pkg::OP_MOVH: begin
        wd = 1'b1;
        new_d = {item.byte_value, dst_full[7:0]};
      end
      default: begin
        wd = 1'b0;
      end
    endcase
    if (wd) begin
      wr.we_a   = d_ok;
      wr.addr_a = item.dest_reg;
      wr.data_a = new_d;
      result    = d_ok ? new_d : '0;
    end
  end

endmodule
